>>> hdl/bsws_pkg.sv
// Shared types, constants, tables and microcode for the square wave sweep unit.
package bsws_pkg;

  localparam int unsigned PHASE_BITS_DEF = 16;
  localparam int unsigned TERM_LIMIT_DEF = 15;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SAMPLE_W    = 15;
  localparam int unsigned TERMS_W     = 4;
  localparam int unsigned PHASE_OUT_W = 16;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned MAG_W       = 15;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_IDX_W = 5;
  localparam int unsigned CLAMP_W     = 5;
  localparam int unsigned HOLD_W      = 8;
  localparam int unsigned MAXT_W      = 4;

  localparam int SAMPLE_MAX = 16383;
  localparam int SAMPLE_MIN = -16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_HOLD_TICKS = 2'd1,
    REG_MAX_TERMS  = 2'd2
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 16'd782;
  localparam logic [HOLD_W-1:0]     HOLD_TICKS_RST = 8'd250;
  localparam logic [MAXT_W-1:0]     MAX_TERMS_RST  = 4'd7;

  // Quarter-wave sine, Q1.14
  localparam logic [MAG_W-1:0] QUARTER_SINE [33] = '{
    15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,  15'd5520,
    15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,  15'd10394, 15'd11003,
    15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623, 15'd14053, 15'd14449, 15'd14811,
    15'd15137, 15'd15426, 15'd15679, 15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364,
    15'd16384
  };

  // round(65536/i) for odd i, Q1.16
  localparam logic [RECIP_W-1:0] ODD_RECIP [31] = '{
    17'd65536, 17'd21845, 17'd13107, 17'd9362, 17'd7282, 17'd5958, 17'd5041, 17'd4369,
    17'd3855,  17'd3449,  17'd3121,  17'd2849, 17'd2621, 17'd2427, 17'd2260, 17'd2114,
    17'd1986,  17'd1872,  17'd1771,  17'd1680, 17'd1598, 17'd1524, 17'd1456, 17'd1394,
    17'd1337,  17'd1285,  17'd1237,  17'd1192, 17'd1150, 17'd1111, 17'd1074
  };

  typedef enum logic [1:0] {
    STEP_WAIT  = 2'd0,
    STEP_LOOP  = 2'd1,
    STEP_DRAIN = 2'd2,
    STEP_OUT   = 2'd3
  } step_e;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_NO_START = 2'd1,
    COND_MORE     = 2'd2,
    COND_OUT_BUSY = 2'd3
  } jcond_e;

  typedef struct packed {
    logic in_rdy;
    logic sine_en;
    logic mac_en;
    logic out_ld;
  } ctrl_t;

  typedef struct packed {
    logic more;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    ctrl_t  ctrl;
    jcond_e cond;
    step_e  tgt;
  } ucode_t;

  // Fall-through goes to the next step, wrapping to the wait step.
  localparam ucode_t UCODE [4] = '{
    '{ctrl: '{in_rdy: 1'b1, sine_en: 1'b0, mac_en: 1'b0, out_ld: 1'b0},
      cond: COND_NO_START, tgt: STEP_WAIT},
    '{ctrl: '{in_rdy: 1'b0, sine_en: 1'b1, mac_en: 1'b1, out_ld: 1'b0},
      cond: COND_MORE, tgt: STEP_LOOP},
    '{ctrl: '{in_rdy: 1'b0, sine_en: 1'b0, mac_en: 1'b1, out_ld: 1'b0},
      cond: COND_NEVER, tgt: STEP_WAIT},
    '{ctrl: '{in_rdy: 1'b0, sine_en: 1'b0, mac_en: 1'b0, out_ld: 1'b1},
      cond: COND_OUT_BUSY, tgt: STEP_OUT}
  };

endpackage

>>> hdl/bsws_if.sv
// Valid/ready channel interfaces for tick input and sample output words.
interface bsws_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface bsws_result_if
  import bsws_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [TERMS_W-1:0]        terms_used;
  logic [PHASE_OUT_W-1:0]    phase_now;

  modport source (output valid, output sample, output terms_used, output phase_now,
                  input ready);
  modport sink   (input valid, input sample, input terms_used, input phase_now,
                  output ready);
endinterface

>>> hdl/bsws_sine.sv
// Quarter-wave table sine with linear interpolation, registered magnitude and sign.
module bsws_sine
  import bsws_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output logic [MAG_W-1:0]   mag_o,
  output logic               neg_o
);

  logic [1:0]       quad;
  logic [MAG_W-1:0] x;
  logic [MAG_W-1:0] p;
  logic [5:0]       idx;
  logic [5:0]       idx_hi;
  logic [8:0]       frac;
  logic [MAG_W-1:0] lo;
  logic [MAG_W-1:0] hi;
  logic [MAG_W-1:0] diff_w;
  logic [18:0]      prod;
  logic [18:0]      rnd;
  logic [MAG_W-1:0] mag_d;
  logic [MAG_W-1:0] mag_q;
  logic             neg_q;

  always_comb begin
    quad   = angle_i[15:14];
    x      = {1'b0, angle_i[13:0]};
    p      = quad[0] ? (15'h4000 - x) : x;
    idx    = p[14:9];
    frac   = p[8:0];
    idx_hi = (idx == 6'd32) ? idx : (idx + 6'd1);
    lo     = QUARTER_SINE[idx];
    hi     = QUARTER_SINE[idx_hi];
    diff_w = hi - lo;
    prod   = {9'b0, diff_w[9:0]} * {10'b0, frac};
    rnd    = prod + 19'd256;
    mag_d  = lo + {5'b0, rnd[18:9]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= quad[1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

>>> hdl/bsws_datapath.sv
// Sweep and phase state, harmonic phase stepping, multiply-accumulate and output register.
module bsws_datapath
  import bsws_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF,
  parameter int unsigned TERM_LIMIT = TERM_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctrl_t                       ctrl_i,
  input  logic                        start_i,
  input  logic [CFG_DATA_W-1:0]       phase_step_i,
  input  logic [HOLD_W-1:0]           hold_ticks_i,
  input  logic [MAXT_W-1:0]           max_terms_i,
  input  logic                        out_ready_i,
  output dp_stat_t                    stat_o,
  output logic                        out_valid_o,
  output logic signed [SAMPLE_W-1:0]  sample_o,
  output logic [TERMS_W-1:0]          terms_used_o,
  output logic [PHASE_OUT_W-1:0]      phase_now_o
);

  localparam int unsigned TC_W  = $clog2(TERM_LIMIT + 1);
  localparam int unsigned ACC_W = MAG_W + 1 + $clog2(TERM_LIMIT);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] hp_q, hp_d;
  logic [TC_W-1:0]       tc_q, tc_d;
  logic                  up_q, up_d;
  logic [HOLD_W-1:0]     hold_q, hold_d;
  logic [TC_W-1:0]       k_q, k_d;
  logic [TC_W-1:0]       kp_q;
  logic                  pv_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                  out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [TERMS_W-1:0]    terms_q;
  logic [PHASE_OUT_W-1:0] phout_q;

  logic [CLAMP_W-1:0]    max_w;
  logic [CLAMP_W-1:0]    top_w;
  logic [TC_W-1:0]       top;
  logic [ANGLE_W-1:0]    angle;
  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic [31:0]           prod;
  logic [32:0]           rnd;
  logic signed [ACC_W-1:0] term;
  logic                  mac_act;
  logic                  out_busy;
  logic                  out_load;
  logic signed [SAMPLE_W-1:0] sat;

  generate
    if (PHASE_BITS >= ANGLE_W) begin : g_wide
      assign angle = hp_q[PHASE_BITS-1 -: ANGLE_W];
    end else begin : g_narrow
      assign angle = {hp_q, {(ANGLE_W - PHASE_BITS){1'b0}}};
    end
  endgenerate

  bsws_sine u_sine (
    .clk_i   (clk_i),
    .en_i    (ctrl_i.sine_en),
    .angle_i (angle),
    .mag_o   (mag),
    .neg_o   (neg)
  );

  // sweep and phase, once per accepted tick
  always_comb begin
    max_w = {1'b0, max_terms_i};
    if (max_w < CLAMP_W'(2)) begin
      top_w = CLAMP_W'(2);
    end else if (max_w > CLAMP_W'(TERM_LIMIT)) begin
      top_w = CLAMP_W'(TERM_LIMIT);
    end else begin
      top_w = max_w;
    end
    top = TC_W'(top_w);

    tc_d    = tc_q;
    up_d    = up_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    if (start_i) begin
      if (hold_q >= hold_ticks_i) begin
        hold_d = '0;
        if (up_q) begin
          if (tc_q >= top) begin
            tc_d = tc_q - TC_W'(1);
            up_d = 1'b0;
          end else begin
            tc_d = tc_q + TC_W'(1);
          end
        end else begin
          if (tc_q <= TC_W'(1)) begin
            tc_d = TC_W'(2);
            up_d = 1'b1;
          end else begin
            tc_d = tc_q - TC_W'(1);
          end
        end
      end else begin
        hold_d = hold_q + HOLD_W'(1);
      end
      phase_d = phase_q + PHASE_BITS'(phase_step_i);
    end
  end

  // harmonic phase and term index
  always_comb begin
    hp_d = hp_q;
    k_d  = k_q;
    if (start_i) begin
      hp_d = phase_d;
      k_d  = '0;
    end else if (ctrl_i.sine_en) begin
      hp_d = hp_q + {phase_q[PHASE_BITS-2:0], 1'b0};
      k_d  = k_q + TC_W'(1);
    end
  end

  assign mac_act = ctrl_i.mac_en & pv_q;

  always_comb begin
    prod = {17'b0, mag} * {15'b0, ODD_RECIP[RECIP_IDX_W'(kp_q)]};
    rnd  = {1'b0, prod} + 33'd32768;
    term = neg ? -ACC_W'($signed({1'b0, rnd[30:16]})) : ACC_W'($signed({1'b0, rnd[30:16]}));
    acc_d = acc_q;
    if (start_i) begin
      acc_d = '0;
    end else if (mac_act) begin
      acc_d = acc_q + term;
    end
  end

  always_comb begin
    if (acc_q > SAT_HI) begin
      sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (acc_q < SAT_LO) begin
      sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sat = acc_q[SAMPLE_W-1:0];
    end
  end

  assign out_busy = out_valid_q & ~out_ready_i;
  assign out_load = ctrl_i.out_ld & ~out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tc_q        <= TC_W'(1);
      up_q        <= 1'b1;
      hold_q      <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tc_q    <= tc_d;
      up_q    <= up_d;
      hold_q  <= hold_d;
      pv_q    <= ctrl_i.sine_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hp_q  <= hp_d;
    k_q   <= k_d;
    acc_q <= acc_d;
    if (ctrl_i.sine_en) begin
      kp_q <= k_q;
    end
    if (out_load) begin
      sample_q <= sat;
      terms_q  <= TERMS_W'(tc_q);
      phout_q  <= PHASE_OUT_W'(phase_q);
    end
  end

  assign stat_o.more     = ((k_q + TC_W'(1)) < tc_q);
  assign stat_o.out_busy = out_busy;
  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign terms_used_o    = terms_q;
  assign phase_now_o     = phout_q;

  a_term_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_act |-> kp_q < tc_q)
    else $error("term index past term count");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.out_ld))
    else $error("output word without load step");

endmodule

>>> hdl/bsws_sequencer.sv
// Step counter and microcode ROM driving the datapath.
module bsws_sequencer
  import bsws_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o
);

  step_e  step_q, step_d;
  ucode_t uw;
  logic   jump;

  assign uw = UCODE[step_q];

  always_comb begin
    case (uw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_START: jump = ~start_i;
      COND_MORE:     jump = stat_i.more;
      COND_OUT_BUSY: jump = stat_i.out_busy;
      default:       jump = 1'b0;
    endcase
    step_d = jump ? uw.tgt : step_e'(step_q + 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = uw.ctrl;

  a_start_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && step_q == STEP_WAIT) |=> step_q == STEP_LOOP)
    else $error("accepted tick did not enter loop");

  a_drain_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_DRAIN |=> step_q == STEP_OUT)
    else $error("drain not followed by output step");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_OUT && !stat_i.out_busy) |=> step_q == STEP_WAIT)
    else $error("output step did not return to wait");

endmodule

>>> hdl/bandlimited_square_wave_sweep_unit.sv
// Band-limited square wave sweep unit: top level with configuration registers.
// An accepted tick of one gives one word of n terms, n the term count (1..TERM_LIMIT).
// One harmonic per cycle on the shared sine and multiplier; no new tick till the word loads.
// A new tick is taken while the previous word still waits in the output register.
// Reset: phase 0, term count 1 counting up, hold count 0; registers 782, 250, 7.
module bandlimited_square_wave_sweep_unit
  import bsws_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF,
  parameter int unsigned TERM_LIMIT = TERM_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bsws_tick_if.sink             tick_in,
  bsws_result_if.source         res_out
);

  logic [CFG_DATA_W-1:0] phase_step_q;
  logic [HOLD_W-1:0]     hold_ticks_q;
  logic [MAXT_W-1:0]     max_terms_q;
  ctrl_t                 ctrl;
  dp_stat_t              stat;
  logic                  start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      hold_ticks_q <= HOLD_TICKS_RST;
      max_terms_q  <= MAX_TERMS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PHASE_STEP: phase_step_q <= cfg_wdata_i;
        REG_HOLD_TICKS: hold_ticks_q <= cfg_wdata_i[HOLD_W-1:0];
        REG_MAX_TERMS:  max_terms_q  <= cfg_wdata_i[MAXT_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_in.ready = ctrl.in_rdy;
  assign start         = tick_in.valid & ctrl.in_rdy & tick_in.tick;

  bsws_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  bsws_datapath #(
    .PHASE_BITS (PHASE_BITS),
    .TERM_LIMIT (TERM_LIMIT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .start_i      (start),
    .phase_step_i (phase_step_q),
    .hold_ticks_i (hold_ticks_q),
    .max_terms_i  (max_terms_q),
    .out_ready_i  (res_out.ready),
    .stat_o       (stat),
    .out_valid_o  (res_out.valid),
    .sample_o     (res_out.sample),
    .terms_used_o (res_out.terms_used),
    .phase_now_o  (res_out.phase_now)
  );

endmodule
